>>> sv/bvs_pkg.sv
// Shared types and constants for the bit vector similarity engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package bvs_pkg;

    localparam int MAX_VECTOR_BITS = 4096;
    localparam int WORD_BITS       = 64;
    localparam int WB_LOG          = $clog2(WORD_BITS);
    localparam int WORDS_MAX       = MAX_VECTOR_BITS / WORD_BITS;
    localparam int POS_W           = $clog2(WORDS_MAX + 1);
    localparam int FIELD_W         = 64;
    localparam int LANES           = 4;
    localparam int LANE_BITS       = WORD_BITS / LANES;
    localparam int LANE_CW         = $clog2(LANE_BITS + 1);
    localparam int VALID_W         = $clog2(WORD_BITS + 1);
    localparam int CNT_W           = 13;
    localparam int ONE_Q16         = 65536;
    localparam int Q_W             = 18;
    localparam int NUM_W           = 45;
    localparam int DEN_W           = 29;
    localparam int CFG_W           = 17;

    localparam logic [1:0] CFG_METRIC = 2'd0;
    localparam logic [1:0] CFG_ALPHA  = 2'd1;
    localparam logic [1:0] CFG_BETA   = 2'd2;
    localparam logic [1:0] CFG_LENGTH = 2'd3;

    typedef enum logic [3:0] {
        M_TANIMOTO = 4'd0,
        M_TVERSKY  = 4'd1,
        M_COSINE   = 4'd2,
        M_KULCZ    = 4'd3,
        M_DICE     = 4'd4,
        M_SOKAL    = 4'd5,
        M_MCCONN   = 4'd6,
        M_ASYM     = 4'd7,
        M_BRAUN    = 4'd8,
        M_RUSSEL   = 4'd9,
        M_ROGOT    = 4'd10,
        M_ONBIT    = 4'd11,
        M_ALLBIT   = 4'd12,
        M_ONPROJ   = 4'd13,
        M_OFFPROJ  = 4'd14
    } t_metric;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_PROD,
        S_SETUP,
        S_RUN1,
        S_RUN2,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [FIELD_W-1:0] word_a;
        logic [FIELD_W-1:0] word_b;
        logic               last_word;
    } t_in_word;

    typedef struct packed {
        logic signed [17:0] similarity;
        logic [16:0]        second_similarity;
        logic [12:0]        common_on;
        logic [12:0]        count_first;
        logic [12:0]        count_second;
        logic               is_subset;
        logic               undefined_flag;
    } t_out_word;

    typedef struct packed {
        logic [LANE_CW-1:0] cnt_a;
        logic [LANE_CW-1:0] cnt_b;
        logic [LANE_CW-1:0] cnt_ab;
    } t_lane_cnt;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [25:0] xx;
        logic [25:0] p;
    } t_cos_req;

endpackage

`default_nettype wire

>>> sv/bvs_lane.sv
// One popcount lane: masked on-bit counts of a slice of both words and their AND.
// Depends on bvs_pkg.
`default_nettype none

module bvs_lane
    import bvs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_load,
    input  wire logic [LANE_BITS-1:0] i_a,
    input  wire logic [LANE_BITS-1:0] i_b,
    input  wire logic [LANE_BITS-1:0] i_mask,
    output t_lane_cnt                 o_cnt
);

    t_lane_cnt r_cnt;
    t_lane_cnt n_cnt;

    always_comb begin
        logic [LANE_BITS-1:0] a;
        logic [LANE_BITS-1:0] b;
        a = i_a & i_mask;
        b = i_b & i_mask;
        n_cnt = '0;
        for (int j = 0; j < LANE_BITS; j++) begin
            n_cnt.cnt_a  = n_cnt.cnt_a + LANE_CW'(a[j]);
            n_cnt.cnt_b  = n_cnt.cnt_b + LANE_CW'(b[j]);
            n_cnt.cnt_ab = n_cnt.cnt_ab + LANE_CW'(a[j] & b[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

>>> sv/bvs_div.sv
// Restoring divider: round(num * 2^16... prescaled) as floor((2s + d) / 2d), one bit a cycle.
// Depends on bvs_pkg.
`default_nettype none

module bvs_div
    import bvs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_div_req   i_req,
    output logic            o_done,
    output logic [Q_W-1:0]  o_quot
);

    localparam int N_W = NUM_W + 1;
    localparam int D_W = DEN_W + 1;
    localparam int C_W = $clog2(Q_W + 1);

    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_den;
    logic [Q_W-1:0] r_low;
    logic [Q_W-1:0] r_q;
    logic [C_W-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [N_W-1:0] dividend;
    logic [D_W:0]   trial;
    logic           ge;

    // 2s + d keeps the round-to-nearest in the integer quotient
    assign dividend = {i_req.num, 1'b0} + N_W'(i_req.den);
    assign trial    = {r_rem, r_low[Q_W-1]};
    assign ge       = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= C_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == C_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= D_W'(dividend[N_W-1:Q_W]);
            r_low <= dividend[Q_W-1:0];
            r_den <= {i_req.den, 1'b0};
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(trial - {1'b0, r_den}) : D_W'(trial);
            r_low <= {r_low[Q_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

>>> sv/bvs_cos.sv
// Cosine root search: largest m with (2m-1)^2 * p <= 4 * x^2 * 2^32, one bit a cycle.
// Depends on bvs_pkg; shift-and-add only, no multiplier.
`default_nettype none

module bvs_cos
    import bvs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cos_req i_req,
    output logic          o_done,
    output logic [16:0]   o_root
);

    // s: (2m-1)^2 p, kc: (2m-1) p << (i+2), pq: p << (2i+2)
    logic signed [63:0] r_s;
    logic signed [63:0] r_kc;
    logic signed [63:0] r_pq;
    logic signed [63:0] r_t;
    logic [16:0]        r_bit;
    logic [16:0]        r_m;
    logic               r_busy;
    logic               r_done;

    logic signed [63:0] cand;
    logic signed [63:0] kc_upd;
    logic               ok;

    assign cand   = r_s + r_kc + r_pq;
    assign ok     = cand <= r_t;
    assign kc_upd = ok ? r_kc + (r_pq <<< 1) : r_kc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_t   <= $signed(64'(i_req.xx) << 34);
            r_s   <= $signed(64'(i_req.p));
            r_kc  <= -$signed(64'(i_req.p) << 18);
            r_pq  <= $signed(64'(i_req.p) << 34);
            r_bit <= 17'h10000;
            r_m   <= '0;
        end else if (r_busy) begin
            if (ok) begin
                r_s <= cand;
                r_m <= r_m | r_bit;
            end
            r_kc  <= kc_upd >>> 1;
            r_pq  <= r_pq >>> 2;
            r_bit <= r_bit >> 1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_m;

    a_bit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot(r_bit))
        else $error("root search bit pointer lost");

endmodule

`default_nettype wire

>>> sv/bit_vector_similarity.sv
// Bit vector similarity engine, top level.
// Uses bvs_pkg, bvs_lane (popcount lanes), bvs_div (divider), bvs_cos (root search).
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data): one word per item, a pair of
//   64-bit slices of the two vectors, lowest bit index first; last_word closes a pair.
//   Output channel (o_out_valid/i_out_ready, o_out_data): one word per vector pair,
//   with the selected coefficient in signed Q1.16, the counts and the flags.
//   Config port (i_cfg_we/i_cfg_index/i_cfg_data): metric, Tversky weights, length;
//   write only while no pair is in flight.
// Timing:
//   A non-last word is accepted (four 16-bit popcount lanes register their
//   counts) and then merged (lane counts summed into the accumulators).
//   A last word adds product, setup and one pass of the shared divider or the
//   cosine root search; the two projection metrics run the divider twice.
//   Zero-denominator cases skip the divider.
// Reset: synchronous, active low; counters cleared, config registers take their
//   defaults, no result pending.
// Stall: the result sits in the output register; the engine accepts and counts
//   further words of the next pair meanwhile and only waits at its final step
//   if the output register is still full.
`default_nettype none

module bit_vector_similarity
    import bvs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_word         i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_word             o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    t_metric     r_metric;
    logic [16:0] r_alpha;
    logic [16:0] r_beta;
    logic [12:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= M_TANIMOTO;
            r_alpha  <= 17'd32768;
            r_beta   <= 17'd32768;
            r_len    <= 13'd2048;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_METRIC: r_metric <= t_metric'(i_cfg_data[3:0]);
                CFG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                CFG_BETA:   r_beta   <= i_cfg_data[16:0];
                CFG_LENGTH: r_len    <= i_cfg_data[12:0];
                default:    r_len    <= r_len;
            endcase
        end
    end

    // effective length: 0 counts as 1, clamp at the vector maximum
    logic [CNT_W-1:0] len_eff;
    assign len_eff = (r_len == '0) ? CNT_W'(1)
                   : (r_len > CNT_W'(MAX_VECTOR_BITS)) ? CNT_W'(MAX_VECTOR_BITS) : r_len;

    // ---------------- state ----------------
    t_state r_state;
    t_state n_state;

    logic             accept;
    logic             out_load;
    logic             run_done;
    logic             setup_fix;
    logic             setup_cos;

    logic [POS_W-1:0] r_pos;
    logic             r_last;
    logic [CNT_W-1:0] r_first;
    logic [CNT_W-1:0] r_second;
    logic [CNT_W-1:0] r_both;

    assign accept = i_in_valid && o_in_ready;

    // ---------------- masking and lanes ----------------
    logic [CNT_W-1:0]     base;
    logic [CNT_W-1:0]     rem_bits;
    logic [VALID_W-1:0]   vcnt;
    logic [WORD_BITS-1:0] mask;
    logic                 in_range;

    always_comb begin
        in_range = r_pos < POS_W'(WORDS_MAX);
        base     = CNT_W'(r_pos) << WB_LOG;
        rem_bits = (len_eff > base) ? len_eff - base : '0;
        vcnt     = (rem_bits > CNT_W'(WORD_BITS)) ? VALID_W'(WORD_BITS)
                                                  : VALID_W'(rem_bits);
        for (int j = 0; j < WORD_BITS; j++) begin
            mask[j] = in_range && (VALID_W'(j) < vcnt);
        end
    end

    t_lane_cnt lane_cnt [LANES];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bvs_lane u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_a    (i_in_data.word_a[g*LANE_BITS +: LANE_BITS]),
            .i_b    (i_in_data.word_b[g*LANE_BITS +: LANE_BITS]),
            .i_mask (mask[g*LANE_BITS +: LANE_BITS]),
            .o_cnt  (lane_cnt[g])
        );
    end

    // merge: sum the lanes into the running counts
    logic [CNT_W-1:0] sum_a;
    logic [CNT_W-1:0] sum_b;
    logic [CNT_W-1:0] sum_ab;

    always_comb begin
        sum_a  = '0;
        sum_b  = '0;
        sum_ab = '0;
        for (int k = 0; k < LANES; k++) begin
            sum_a  = sum_a + CNT_W'(lane_cnt[k].cnt_a);
            sum_b  = sum_b + CNT_W'(lane_cnt[k].cnt_b);
            sum_ab = sum_ab + CNT_W'(lane_cnt[k].cnt_ab);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_both   <= '0;
        end else begin
            if (accept && in_range) begin
                r_pos <= r_pos + 1'b1;
            end
            if (r_state == S_MERGE) begin
                r_first  <= r_first + sum_a;
                r_second <= r_second + sum_b;
                r_both   <= r_both + sum_ab;
            end
            if (out_load) begin
                r_pos    <= '0;
                r_first  <= '0;
                r_second <= '0;
                r_both   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_last <= i_in_data.last_word;
        end
    end

    // ---------------- products (one multiplier each, registered) ----------------
    logic [CNT_W-1:0]   r_x, r_y, r_z, r_u, r_l;
    logic [29:0]        r_m0, r_m1;
    logic signed [31:0] r_m2;
    logic [26:0]        r_m3;
    logic [25:0]        r_m4, r_m5;
    logic [28:0]        r_m6;
    logic [27:0]        r_m7;
    logic [26:0]        r_m8;

    always_ff @(posedge i_clk) begin
        logic [CNT_W-1:0]   u;
        logic [CNT_W-1:0]   l;
        logic [16:0]        a;
        logic [16:0]        b;
        logic signed [18:0] c;
        logic [13:0]        d1;
        logic [14:0]        d2;
        if (r_state == S_PROD) begin
            u  = CNT_W'(14'(r_first) + 14'(r_second) - 14'(r_both));
            l  = (len_eff < u) ? u : len_eff;
            a  = (r_alpha > 17'(ONE_Q16)) ? 17'(ONE_Q16) : r_alpha;
            b  = (r_beta > 17'(ONE_Q16)) ? 17'(ONE_Q16) : r_beta;
            c  = 19'sd65536 - $signed({2'b0, a}) - $signed({2'b0, b});
            d1 = 14'(r_first) + 14'(r_second);
            d2 = (15'(l) << 1) - 15'(d1);
            r_x  <= r_both;
            r_y  <= r_first;
            r_z  <= r_second;
            r_u  <= u;
            r_l  <= l;
            r_m0 <= 30'(a) * 30'(r_first);
            r_m1 <= 30'(b) * 30'(r_second);
            r_m2 <= 32'(c) * $signed({19'b0, r_both});
            r_m3 <= 27'(r_both) * 27'(d1);
            r_m4 <= 26'(r_first) * 26'(r_second);
            r_m5 <= 26'(r_both) * 26'(r_both);
            r_m6 <= 29'(d1) * 29'(d2);
            r_m7 <= 28'(r_both) * 28'(d2);
            r_m8 <= 27'(l - u) * 27'(d1);
        end
    end

    // ---------------- setup: pick numerator and denominator ----------------
    logic signed [Q_W-1:0] setup_fixval;
    logic                  setup_neg, setup_undef, setup_two, setup_wide;
    logic [28:0]           setup_n1, setup_n2;
    logic [DEN_W-1:0]      setup_d1, setup_d2;
    logic [NUM_W-1:0]      setup_s1;

    always_comb begin
        logic [13:0]        ysum;
        logic [15:0]        ds;
        logic signed [32:0] dt;
        logic signed [28:0] nm;
        logic [CNT_W-1:0]   mn, mx, off;
        ysum = 14'(r_y) + 14'(r_z);
        ds   = (16'(r_y) << 1) + (16'(r_z) << 1) - ((16'(r_x) << 1) + 16'(r_x));
        dt   = $signed({3'b0, r_m0}) + $signed({3'b0, r_m1}) + 33'(r_m2);
        nm   = $signed({2'b0, r_m3}) - $signed({3'b0, r_m4});
        mn   = (r_y < r_z) ? r_y : r_z;
        mx   = (r_y > r_z) ? r_y : r_z;
        off  = r_l - r_u;
        setup_fix    = 1'b0;
        setup_fixval = '0;
        setup_neg    = 1'b0;
        setup_undef  = 1'b0;
        setup_cos    = 1'b0;
        setup_two    = 1'b0;
        setup_wide   = 1'b0;
        setup_n1     = 29'(r_x);
        setup_d1     = DEN_W'(1);
        setup_n2     = 29'(r_x);
        setup_d2     = DEN_W'(1);
        case (r_metric)
            M_TANIMOTO: begin
                if (r_u == '0) begin
                    setup_fix    = 1'b1;
                    setup_fixval = Q_W'(ONE_Q16);
                end else begin
                    setup_d1 = DEN_W'(r_u);
                end
            end
            M_TVERSKY: begin
                if (dt <= 0) begin
                    setup_fix    = 1'b1;
                    setup_fixval = Q_W'(ONE_Q16);
                end else begin
                    setup_wide = 1'b1;
                    setup_d1   = DEN_W'(dt);
                end
            end
            M_COSINE: begin
                if (r_m4 == '0) setup_fix = 1'b1;
                else            setup_cos = 1'b1;
            end
            M_KULCZ: begin
                if (r_m4 == '0) begin
                    setup_fix = 1'b1;
                end else begin
                    setup_n1 = 29'(r_m3);
                    setup_d1 = DEN_W'(r_m4) << 1;
                end
            end
            M_DICE: begin
                if (ysum == '0) begin
                    setup_fix = 1'b1;
                end else begin
                    setup_n1 = 29'(r_x) << 1;
                    setup_d1 = DEN_W'(ysum);
                end
            end
            M_SOKAL: begin
                if (ds == '0) begin
                    setup_fix   = 1'b1;
                    setup_undef = 1'b1;
                end else begin
                    setup_d1 = DEN_W'(ds);
                end
            end
            M_MCCONN: begin
                if (r_m4 == '0) begin
                    setup_fix = 1'b1;
                end else begin
                    setup_neg = nm < 0;
                    setup_n1  = (nm < 0) ? 29'(-nm) : 29'(nm);
                    setup_d1  = DEN_W'(r_m4);
                end
            end
            M_ASYM: begin
                if (mn == '0) setup_fix = 1'b1;
                else          setup_d1  = DEN_W'(mn);
            end
            M_BRAUN: begin
                if (mx == '0) setup_fix = 1'b1;
                else          setup_d1  = DEN_W'(mx);
            end
            M_RUSSEL: begin
                setup_d1 = DEN_W'(r_l);
            end
            M_ROGOT: begin
                // all on in both, or all off in both
                if (r_x == r_l || r_u == '0) begin
                    setup_fix    = 1'b1;
                    setup_fixval = Q_W'(ONE_Q16);
                end else begin
                    setup_n1 = 29'(r_m7) + 29'(r_m8);
                    setup_d1 = DEN_W'(r_m6);
                end
            end
            M_ONBIT: begin
                if (r_u == '0) setup_fix = 1'b1;
                else           setup_d1  = DEN_W'(r_u);
            end
            M_ALLBIT: begin
                setup_n1 = 29'(off) + 29'(r_x);
                setup_d1 = DEN_W'(r_l);
            end
            M_ONPROJ: begin
                if (r_x == '0) begin
                    setup_fix = 1'b1;
                end else begin
                    setup_two = 1'b1;
                    setup_d1  = DEN_W'(r_y);
                    setup_d2  = DEN_W'(r_z);
                end
            end
            M_OFFPROJ: begin
                if (off == '0) begin
                    setup_fix = 1'b1;
                end else begin
                    setup_two = 1'b1;
                    setup_n1  = 29'(off);
                    setup_n2  = 29'(off);
                    setup_d1  = DEN_W'(r_l - r_y);
                    setup_d2  = DEN_W'(r_l - r_z);
                end
            end
            default: setup_fix = 1'b1;
        endcase
        // Tversky carries x * 2^32 as numerator, everyone else n * 2^16
        setup_s1 = setup_wide ? (NUM_W'(r_x) << 32) : (NUM_W'(setup_n1) << 16);
    end

    logic                  r_fix, r_neg, r_undef, r_cos, r_two;
    logic signed [Q_W-1:0] r_fixval;
    logic [NUM_W-1:0]      r_s2;
    logic [DEN_W-1:0]      r_d2;
    logic [Q_W-1:0]        r_q1;
    logic [16:0]           r_q2;

    // ---------------- shared arithmetic units ----------------
    t_div_req       div_req;
    t_cos_req       cos_req;
    logic           div_done;
    logic [Q_W-1:0] div_quot;
    logic           cos_done;
    logic [16:0]    cos_root;

    bvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    bvs_cos u_cos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cos_req),
        .o_done  (cos_done),
        .o_root  (cos_root)
    );

    assign run_done = r_cos ? cos_done : div_done;

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_MERGE;
            S_MERGE: n_state = r_last ? S_PROD : S_IDLE;
            S_PROD:  n_state = S_SETUP;
            S_SETUP: n_state = setup_fix ? S_FIN : S_RUN1;
            S_RUN1:  if (run_done) n_state = r_two ? S_RUN2 : S_FIN;
            S_RUN2:  if (div_done) n_state = S_FIN;
            S_FIN:   if (!o_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = r_state == S_IDLE;
        out_load      = (r_state == S_FIN) && (!o_out_valid || i_out_ready);
        div_req.start = ((r_state == S_SETUP) && !setup_fix && !setup_cos)
                     || ((r_state == S_RUN1) && div_done && r_two);
        div_req.num   = (r_state == S_SETUP) ? setup_s1 : r_s2;
        div_req.den   = (r_state == S_SETUP) ? setup_d1 : r_d2;
        cos_req.start = (r_state == S_SETUP) && !setup_fix && setup_cos;
        cos_req.xx    = r_m5;
        cos_req.p     = r_m4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // setup and result capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_fix    <= setup_fix;
            r_fixval <= setup_fixval;
            r_neg    <= setup_neg;
            r_undef  <= setup_undef;
            r_cos    <= setup_cos;
            r_two    <= setup_two && !setup_fix;
            r_s2     <= NUM_W'(setup_n2) << 16;
            r_d2     <= setup_d2;
        end
        if (r_state == S_RUN1 && run_done) begin
            r_q1 <= r_cos ? Q_W'(cos_root) : div_quot;
        end
        if (r_state == S_RUN2 && div_done) begin
            r_q2 <= div_quot[16:0];
        end
    end

    // ---------------- output register ----------------
    t_out_word r_out;
    logic      r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.similarity        <= r_fix ? r_fixval
                                     : (r_neg ? -$signed(r_q1) : $signed(r_q1));
            r_out.second_similarity <= (r_two && !r_fix) ? r_q2 : '0;
            r_out.common_on         <= r_x;
            r_out.count_first       <= r_y;
            r_out.count_second      <= r_z;
            r_out.is_subset         <= r_x == r_y;
            r_out.undefined_flag    <= r_fix && r_undef;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- checks ----------------
    a_counts_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_both <= r_first) && (r_both <= r_second))
        else $error("common count exceeds a vector count");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(WORDS_MAX))
        else $error("word position beyond vector");

    a_clear_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_both == '0) && (r_pos == '0))
        else $error("counts not cleared after result");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.similarity <= 18'sd65536)
                     && (o_out_data.similarity >= -18'sd65536))
        else $error("similarity out of Q1.16 range");

endmodule

`default_nettype wire
